// File: sv/mexp_pkg.sv
// mexp_pkg: constants shared by the modular exponentiation pipeline
// no dependencies
`default_nettype none

package mexp_pkg;

  localparam int unsigned EXP_BITS  = 63;  // exponent bits scanned, 1..63
  localparam int unsigned MUL_LAT   = 4;   // register stages of one modular multiply

  localparam logic [29:0] PRIME     = 30'd998244353;
  localparam logic [29:0] ONE       = 30'd1;
  // barrett constant floor(2^60 / prime)
  localparam logic [30:0] MU        = 31'((64'd1 << 60) / 64'd998244353);

  typedef logic [29:0] res_t;
  typedef logic [62:0] exp_t;

  typedef struct packed {
    logic valid;
    exp_t exp;
  } side_t;

endpackage

`default_nettype wire

// File: sv/mexp_modmul.sv
// mexp_modmul: four-stage a*b mod prime with barrett reduction
// depends on mexp_pkg
`default_nettype none

module mexp_modmul (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire mexp_pkg::res_t a_i,
  input  wire mexp_pkg::res_t b_i,
  output mexp_pkg::res_t     r_o
);
  import mexp_pkg::*;

  logic [59:0] p_q;
  logic [61:0] t_q;
  logic [31:0] plo2_q, plo3_q, qm_q;
  logic [30:0] q;
  logic [31:0] r0, r1, r2;
  res_t        r_q;

  assign q  = t_q[61:31];
  assign r0 = plo3_q - qm_q;
  assign r1 = (r0 >= {2'b00, PRIME}) ? r0 - {2'b00, PRIME} : r0;
  assign r2 = (r1 >= {2'b00, PRIME}) ? r1 - {2'b00, PRIME} : r1;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q    <= {30'd0, a_i} * {30'd0, b_i};
      t_q    <= {31'd0, p_q[59:29]} * {31'd0, MU};
      plo2_q <= p_q[31:0];
      qm_q   <= 32'({32'd0, q} * {33'd0, PRIME});
      plo3_q <= plo2_q;
      r_q    <= r2[29:0];
    end
  end

  assign r_o = r_q;

endmodule

`default_nettype wire

// File: sv/mexp_step.sv
// mexp_step: one exponent bit, multiply and square in parallel
// depends on mexp_pkg and mexp_modmul
`default_nettype none

module mexp_step (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire mexp_pkg::side_t side_i,
  input  wire mexp_pkg::res_t  acc_i,
  input  wire mexp_pkg::res_t  sq_i,
  output mexp_pkg::side_t      side_o,
  output mexp_pkg::res_t       acc_o,
  output mexp_pkg::res_t       sq_o
);
  import mexp_pkg::*;

  logic [MUL_LAT-1:0] vld_q;
  exp_t               exp_q [MUL_LAT];
  res_t               mul_b;

  // bit clear: multiply by one so the accumulator passes through
  assign mul_b = side_i.exp[0] ? sq_i : ONE;

  mexp_modmul u_acc (.clk_i, .en_i, .a_i(acc_i), .b_i(mul_b), .r_o(acc_o));
  mexp_modmul u_sq  (.clk_i, .en_i, .a_i(sq_i),  .b_i(sq_i),  .r_o(sq_o));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[MUL_LAT-2:0], side_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      exp_q[0] <= side_i.exp >> 1;
      for (int i = 1; i < MUL_LAT; i++) exp_q[i] <= exp_q[i-1];
    end
  end

  assign side_o.valid = vld_q[MUL_LAT-1];
  assign side_o.exp   = exp_q[MUL_LAT-1];

endmodule

`default_nettype wire

// File: sv/modular_exponentiation.sv
// modular_exponentiation: base^exponent mod 998244353, fully pipelined
// depends on mexp_pkg, mexp_step, mexp_modmul
//
// channel   dir  tdata fields (low bit up)
// s_axis    in   base[29:0], exponent[92:30], zero pad to 96
// m_axis    out  power[29:0], zero pad to 32
//
// one word enters per cycle unless a held output word stalls the pipe; an input register feeds the first step
// each exponent bit is one four-stage pair of modular multipliers
// reset clears only the valid bits; payload registers are not reset
// the whole pipe advances together; a held output word freezes every stage
`default_nettype none

module modular_exponentiation (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,   // base[29:0], exponent[92:30]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata    // power[29:0]
);
  import mexp_pkg::*;

  logic  en;
  logic  in_vld_q;
  res_t  base_q;
  exp_t  exp_q;
  res_t  base_red;
  side_t side [EXP_BITS+1];
  res_t  acc  [EXP_BITS+1];
  res_t  sq   [EXP_BITS+1];

  // global advance: output slot empty or being taken
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // base below 2^30 is below twice the prime, one subtract reduces it
  assign base_red = (s_axis_tdata[29:0] >= PRIME) ? s_axis_tdata[29:0] - PRIME
                                                  : s_axis_tdata[29:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      base_q <= base_red;
      exp_q  <= s_axis_tdata[92:30];
    end
  end

  assign side[0].valid = in_vld_q;
  assign side[0].exp   = exp_q;
  assign acc[0]        = ONE;
  assign sq[0]         = base_q;

  // one stage group per exponent bit, lsb first
  for (genvar g = 0; g < EXP_BITS; g++) begin : g_bit
    mexp_step u_step (
      .clk_i,
      .rst_ni,
      .en_i   (en),
      .side_i (side[g]),
      .acc_i  (acc[g]),
      .sq_i   (sq[g]),
      .side_o (side[g+1]),
      .acc_o  (acc[g+1]),
      .sq_o   (sq[g+1])
    );
  end

  // last square and leftover exponent bits are dropped
  logic unused;
  assign unused = ^{sq[EXP_BITS], side[EXP_BITS].exp, s_axis_tdata[95:93]};

  assign m_axis_tvalid = side[EXP_BITS].valid;
  assign m_axis_tdata  = {2'b00, acc[EXP_BITS]};

endmodule

`default_nettype wire
